// File: src/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants for the pressure sensor autorange block.
// ----------------------------------------------------------------------------
package psa_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 10;

	localparam int unsigned PTP_BITS    = 10;
	localparam int unsigned DELTA_BITS  = 9;
	localparam int unsigned THR_BITS    = 8;
	localparam int unsigned CFG_DW      = 10;
	localparam int unsigned CFG_IW      = 2;

	typedef enum logic [CFG_IW-1:0] {
		REG_PEAK_TO_PEAK = 2'd0,
		REG_PRESS_DELTA  = 2'd1,
		REG_STUCK_LIMIT  = 2'd2,
		REG_IDLE_LIMIT   = 2'd3
	} reg_idx_t;

	localparam logic [PTP_BITS-1:0]   PTP_RESET       = 10'd20;
	localparam logic [DELTA_BITS-1:0] DELTA_RESET     = 9'd20;
	localparam logic [THR_BITS-1:0]   BLOCK_THR_RESET = 8'd4;
	localparam logic [THR_BITS-1:0]   IDLE_THR_RESET  = 8'd10;

	typedef struct packed {
		logic [PTP_BITS-1:0]   peak_to_peak;
		logic [DELTA_BITS-1:0] press_delta;
		logic [THR_BITS-1:0]   stuck_limit;
		logic [THR_BITS-1:0]   idle_limit;
	} cfg_t;

endpackage

// File: src/psa_sample_if.sv
// ----------------------------------------------------------------------------
// psa_sample_if
// Input channel: one raw sensor sample per beat.
// ----------------------------------------------------------------------------
interface psa_sample_if #(
	parameter int unsigned SAMPLE_BITS = psa_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// File: src/psa_result_if.sv
// ----------------------------------------------------------------------------
// psa_result_if
// Output channel: pressure, calibrated flag and span per beat.
// ----------------------------------------------------------------------------
interface psa_result_if #(
	parameter int unsigned SAMPLE_BITS = psa_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] pressure;
	logic                   calibrated;
	logic [SAMPLE_BITS-1:0] span;

	modport source (output valid, output pressure, output calibrated, output span, input ready);
	modport sink   (input valid, input pressure, input calibrated, input span, output ready);
endinterface

// File: src/psa_cfg.sv
// ----------------------------------------------------------------------------
// psa_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module psa_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psa_pkg::CFG_IW-1:0]  cfg_idx,
	input  logic [psa_pkg::CFG_DW-1:0]  cfg_wdata,
	output psa_pkg::cfg_t               cfg
);
	import psa_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_to_peak <= PTP_RESET;
			cfg_q.press_delta  <= DELTA_RESET;
			cfg_q.stuck_limit  <= BLOCK_THR_RESET;
			cfg_q.idle_limit   <= IDLE_THR_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_PEAK_TO_PEAK: begin
					cfg_q.peak_to_peak <= cfg_wdata[PTP_BITS-1:0];
				end
				REG_PRESS_DELTA: begin
					cfg_q.press_delta <= cfg_wdata[DELTA_BITS-1:0];
				end
				REG_STUCK_LIMIT: begin
					cfg_q.stuck_limit <= cfg_wdata[THR_BITS-1:0];
				end
				REG_IDLE_LIMIT: begin
					cfg_q.idle_limit <= cfg_wdata[THR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/psa_track.sv
// ----------------------------------------------------------------------------
// psa_track
// Tracker state and its update on each step: average, extremes, calibration,
// re-arm counters and the result for the current sample.
// ----------------------------------------------------------------------------
module psa_track #(
	parameter int unsigned SAMPLE_BITS = psa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample_s1,
	input  psa_pkg::cfg_t          cfg,
	output logic [SAMPLE_BITS-1:0] pressure,
	output logic                   calibrated,
	output logic [SAMPLE_BITS-1:0] span
);
	import psa_pkg::*;

	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned AW = SB + 3;
	localparam int unsigned DW = (SB > DELTA_BITS) ? SB : DELTA_BITS;
	localparam int unsigned PW = (SB > DELTA_BITS + 1) ? SB : DELTA_BITS + 1;

	logic [SB-1:0]       avg_q, abs_lo_q, abs_hi_q, run_lo_q, run_hi_q, last_p_q;
	logic                cal_q;
	logic [THR_BITS-1:0] idle_cnt_q, stuck_cnt_q;

	logic [SB-1:0]         abs_lo_n, abs_hi_n, avg_n;
	logic [AW-1:0]         acc;
	logic [SB-1:0]         above, below;
	logic [DELTA_BITS-1:0] half;
	logic                  cal_ok;
	logic [SB-1:0]         run_lo_c, run_hi_c, run_lo_n, run_hi_n, press_c;
	logic                  is_active, is_high, match;
	logic [THR_BITS-1:0]   stuck_inc, idle_inc, stuck_n, idle_n;
	logic                  stuck_fire, idle_fire;
	logic                  cal_n;

	always_comb begin
		abs_hi_n = (sample_s1 > abs_hi_q) ? sample_s1 : abs_hi_q;
		abs_lo_n = (sample_s1 < abs_lo_q) ? sample_s1 : abs_lo_q;
		acc      = ({avg_q, 3'b000} - {3'b000, avg_q}) + {3'b000, sample_s1};
		avg_n    = acc[AW-1:3];

		half   = cfg.peak_to_peak[PTP_BITS-1:1];
		above  = avg_n - abs_lo_n;
		below  = abs_hi_n - avg_n;
		cal_ok = (avg_n > abs_lo_n) && (DW'(above) > DW'(half))
			&& (abs_hi_n > avg_n) && (DW'(below) > DW'(half));

		run_hi_c = (avg_n > run_hi_q) ? avg_n : run_hi_q;
		run_lo_c = (avg_n < run_lo_q) ? avg_n : run_lo_q;
		press_c  = avg_n - run_lo_c;

		is_active = PW'(press_c) > PW'(cfg.press_delta);
		is_high   = PW'(press_c) > PW'({cfg.press_delta, 1'b0});
		match     = (press_c == last_p_q) && is_high;

		stuck_inc  = stuck_cnt_q + THR_BITS'(1);
		stuck_fire = match && (stuck_inc == cfg.stuck_limit);
		stuck_n    = (match && !stuck_fire) ? stuck_inc : '0;

		idle_inc  = idle_cnt_q + THR_BITS'(1);
		idle_fire = !is_active && (idle_inc == cfg.idle_limit);
		idle_n    = (is_active || idle_fire) ? '0 : idle_inc;

		if (cal_q) begin
			run_hi_n = run_hi_c;
			run_lo_n = (stuck_fire || idle_fire) ? avg_n : run_lo_c;
			cal_n    = 1'b1;
		end else if (cal_ok) begin
			run_hi_n = run_hi_c;
			run_lo_n = run_lo_c;
			cal_n    = 1'b1;
		end else begin
			run_hi_n = run_hi_q;
			run_lo_n = run_lo_q;
			cal_n    = 1'b0;
		end

		pressure   = cal_q ? press_c : '0;
		calibrated = cal_q;
		span       = (run_hi_n > run_lo_n) ? (run_hi_n - run_lo_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q       <= '0;
			abs_lo_q    <= '1;
			abs_hi_q    <= '0;
			run_lo_q    <= '1;
			run_hi_q    <= '0;
			cal_q       <= 1'b0;
			idle_cnt_q  <= '0;
			stuck_cnt_q <= '0;
			last_p_q    <= '0;
		end else if (step) begin
			avg_q    <= avg_n;
			abs_lo_q <= abs_lo_n;
			abs_hi_q <= abs_hi_n;
			run_lo_q <= run_lo_n;
			run_hi_q <= run_hi_n;
			cal_q    <= cal_n;
			if (cal_q) begin
				idle_cnt_q  <= idle_n;
				stuck_cnt_q <= stuck_n;
				last_p_q    <= press_c;
			end
		end
	end

endmodule

// File: src/pressure_sensor_autorange.sv
// ----------------------------------------------------------------------------
// pressure_sensor_autorange
// Self-calibrating range tracker for a raw pressure sensor reading.
//
// sample_ch takes one raw converter sample per beat; result_ch gives one
// beat per sample with pressure, calibrated and span. Both use valid/ready.
// Registers are written through cfg_we/cfg_idx/cfg_wdata; the user must write
// them only while idle, as the block does not enforce it. A sample accepted on
// sample_ch is held in the input stage, then in the result register (two
// register stages). Throughput: one sample per cycle while result_ch does not
// stall; the tracker updates its state as a sample leaves the input stage.
// When result_ch stalls, the result register holds, the input stage holds
// one more sample, and sample_ch.ready drops once both are full.
// Reset clears the tracker to uncalibrated (average 0, extremes open, counters
// 0), loads the register defaults and empties both stages.
// ----------------------------------------------------------------------------
module pressure_sensor_autorange #(
	parameter int unsigned SAMPLE_BITS = psa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	psa_sample_if.sink                 sample_ch,
	psa_result_if.source               result_ch,
	input  logic                       cfg_we,
	input  logic [psa_pkg::CFG_IW-1:0] cfg_idx,
	input  logic [psa_pkg::CFG_DW-1:0] cfg_wdata
);
	import psa_pkg::*;

	cfg_t                   cfg;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   valid_s2;
	logic [SAMPLE_BITS-1:0] pressure_s2, span_s2;
	logic                   cal_s2;
	logic                   advance;
	logic [SAMPLE_BITS-1:0] pressure_c, span_c;
	logic                   cal_c;

	psa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	psa_track #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.sample_s1  (sample_s1),
		.cfg        (cfg),
		.pressure   (pressure_c),
		.calibrated (cal_c),
		.span       (span_c)
	);

	assign advance         = valid_s1 && (!valid_s2 || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) begin
			sample_s1 <= sample_ch.sample;
		end
		if (advance) begin
			pressure_s2 <= pressure_c;
			cal_s2      <= cal_c;
			span_s2     <= span_c;
		end
	end

	assign result_ch.valid      = valid_s2;
	assign result_ch.pressure   = pressure_s2;
	assign result_ch.calibrated = cal_s2;
	assign result_ch.span       = span_s2;

endmodule

// File: verif/tb_pressure_sensor_autorange.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pressure_sensor_autorange
// Self-checking bench for the pressure sensor autorange tracker.
//
// A directed script first covers the uncalibrated start: an average below the
// absolute low, a spread that cannot be reached, and the calibrating step.
// Random phases follow, each with its own register setting, including the
// extremes and wrapped zero thresholds. Most stimulus is held levels, so that
// the average settles and the idle and stuck re-arms fire; the rest is noise.
// Every accepted sample runs through a local tracker model, and each result
// beat is checked field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pressure_sensor_autorange;
	import psa_pkg::*;

	localparam int unsigned SB = SAMPLE_BITS_DEF;
	localparam int unsigned SAMPLE_MAX = (1 << SB) - 1;

	typedef struct packed {
		logic [SB-1:0] pressure;
		logic          calibrated;
		logic [SB-1:0] span;
	} reading_t;

	typedef struct {
		bit                wr;
		reg_idx_t          idx;
		logic [CFG_DW-1:0] wdata;
		logic [SB-1:0]     sample;
		int                reps;
		bit                typed;
		reading_t          want;
	} script_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_idx;
	logic [CFG_DW-1:0] cfg_wdata;

	psa_sample_if #(.SAMPLE_BITS(SB)) sample_ch ();
	psa_result_if #(.SAMPLE_BITS(SB)) result_ch ();

	pressure_sensor_autorange #(.SAMPLE_BITS(SB)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// tracker model state
	cfg_t          tracker_cfg = '{PTP_RESET, DELTA_RESET, BLOCK_THR_RESET, IDLE_THR_RESET};
	logic [SB-1:0] ma_avg     = '0;
	logic [SB-1:0] abs_lo     = SB'(SAMPLE_MAX);
	logic [SB-1:0] abs_hi     = '0;
	logic [SB-1:0] run_lo     = SB'(SAMPLE_MAX);
	logic [SB-1:0] run_hi     = '0;
	logic          is_cal     = 1'b0;
	logic [7:0]    idle_cnt   = '0;
	logic [7:0]    stuck_cnt  = '0;
	logic [SB-1:0] last_press = '0;

	reading_t pending_readings [$];
	int       mismatches = 0;
	int       burst_left = 0;
	logic     beat_typed;
	reading_t beat_want;
	int       stall_tick = 0;
	int       stall_mode = 0;
	logic [7:0] stall_mask = 8'hFF;

	script_row_t script [11] = '{
		// average starts below the absolute low
		'{1'b0, REG_PEAK_TO_PEAK, 10'd0, 10'd1023, 1, 1'b1, '{10'd0, 1'b0, 10'd0}},
		'{1'b0, REG_PEAK_TO_PEAK, 10'd0, 10'd1023, 1, 1'b1, '{10'd0, 1'b0, 10'd0}},
		// spread beyond reach: never calibrates
		'{1'b1, REG_PEAK_TO_PEAK, 10'd1023, 10'd0, 0, 1'b0, '{10'd0, 1'b0, 10'd0}},
		'{1'b0, REG_PEAK_TO_PEAK, 10'd0, 10'd0, 1, 1'b1, '{10'd0, 1'b0, 10'd0}},
		'{1'b0, REG_PEAK_TO_PEAK, 10'd0, 10'd1023, 1, 1'b1, '{10'd0, 1'b0, 10'd0}},
		'{1'b0, REG_PEAK_TO_PEAK, 10'd0, 10'd512, 1, 1'b1, '{10'd0, 1'b0, 10'd0}},
		// zero spread: the next step calibrates and still reports zeros
		'{1'b1, REG_PEAK_TO_PEAK, 10'd0, 10'd0, 0, 1'b0, '{10'd0, 1'b0, 10'd0}},
		'{1'b0, REG_PEAK_TO_PEAK, 10'd0, 10'd0, 1, 1'b1, '{10'd0, 1'b0, 10'd0}},
		'{1'b0, REG_PEAK_TO_PEAK, 10'd0, 10'd0, 6, 1'b0, '{10'd0, 1'b0, 10'd0}},
		'{1'b0, REG_PEAK_TO_PEAK, 10'd0, 10'd1023, 12, 1'b0, '{10'd0, 1'b0, 10'd0}},
		'{1'b0, REG_PEAK_TO_PEAK, 10'd0, 10'h2AA, 1, 1'b0, '{10'd0, 1'b0, 10'd0}}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic reading_t track_sample(input logic [SB-1:0] s);
		reading_t r;
		int half, above, below;
		r = '0;
		if (s > abs_hi) abs_hi = s;
		if (s < abs_lo) abs_lo = s;
		ma_avg = SB'((int'(ma_avg) * 7 + int'(s)) / 8);
		if (!is_cal) begin
			half  = int'(tracker_cfg.peak_to_peak) / 2;
			above = int'(ma_avg) - int'(abs_lo);
			below = int'(abs_hi) - int'(ma_avg);
			if (above > half && below > half) begin
				if (ma_avg > run_hi) run_hi = ma_avg;
				if (ma_avg < run_lo) run_lo = ma_avg;
				is_cal = 1'b1;
			end
		end else begin
			if (ma_avg > run_hi) run_hi = ma_avg;
			if (ma_avg < run_lo) run_lo = ma_avg;
			r.pressure   = ma_avg - run_lo;
			r.calibrated = 1'b1;
			if (r.pressure == last_press
					&& int'(r.pressure) > 2 * int'(tracker_cfg.press_delta)) begin
				stuck_cnt = stuck_cnt + 8'd1;
				if (stuck_cnt == tracker_cfg.stuck_limit) begin
					run_lo    = ma_avg;
					stuck_cnt = '0;
				end
			end else begin
				stuck_cnt = '0;
			end
			if (int'(r.pressure) > int'(tracker_cfg.press_delta)) begin
				idle_cnt = '0;
			end else begin
				idle_cnt = idle_cnt + 8'd1;
				if (idle_cnt == tracker_cfg.idle_limit) begin
					idle_cnt = '0;
					run_lo   = ma_avg;
				end
			end
			last_press = r.pressure;
		end
		r.span = (run_hi > run_lo) ? run_hi - run_lo : '0;
		return r;
	endfunction

	always @(posedge clk) begin
		reading_t r;
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			r = track_sample(sample_ch.sample);
			pending_readings.push_back(beat_typed ? beat_want : r);
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: expected none, got pressure %0d calibrated %0d span %0d",
					$time, result_ch.pressure, result_ch.calibrated, result_ch.span);
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.pressure !== want.pressure) begin
					$display("%0t: pressure expected %0d got %0d",
						$time, want.pressure, result_ch.pressure);
					mismatches++;
				end
				if (result_ch.calibrated !== want.calibrated) begin
					$display("%0t: calibrated expected %0d got %0d",
						$time, want.calibrated, result_ch.calibrated);
					mismatches++;
				end
				if (result_ch.span !== want.span) begin
					$display("%0t: span expected %0d got %0d",
						$time, want.span, result_ch.span);
					mismatches++;
				end
			end
		end
	end

	// receiver back-pressure: mode (always ready, random, mask pattern) is rerolled
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 64 == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_mask <= 8'($urandom);
		end
		case (stall_mode)
			0: begin
				result_ch.ready <= 1'b1;
			end
			1: begin
				result_ch.ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				result_ch.ready <= stall_mask[stall_tick % 8];
			end
		endcase
	end

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic push_sample(input logic [SB-1:0] s, input bit typed, input reading_t want);
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		beat_typed       <= typed;
		beat_want        <= want;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		pace();
	endtask

	task automatic settle();
		if (sample_ch.valid) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		while (pending_readings.size() != 0) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_DW-1:0] v [4], input logic [3:0] sel);
		reg_idx_t idx;
		settle();
		for (int i = 0; i < 4; i++) begin
			if (sel[i]) begin
				idx = reg_idx_t'(i);
				cfg_we    <= 1'b1;
				cfg_idx   <= idx;
				cfg_wdata <= v[i];
				case (idx)
					REG_PEAK_TO_PEAK: tracker_cfg.peak_to_peak = v[i][PTP_BITS-1:0];
					REG_PRESS_DELTA:  tracker_cfg.press_delta = v[i][DELTA_BITS-1:0];
					REG_STUCK_LIMIT:  tracker_cfg.stuck_limit = v[i][THR_BITS-1:0];
					REG_IDLE_LIMIT:   tracker_cfg.idle_limit = v[i][THR_BITS-1:0];
					default: ;
				endcase
				@(posedge clk);
			end
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic pick_setting(input int ph, output logic [CFG_DW-1:0] v [4]);
		v[REG_PEAK_TO_PEAK] = CFG_DW'($urandom_range(0, 1023));
		v[REG_PRESS_DELTA]  = CFG_DW'($urandom_range(0, 40));
		v[REG_STUCK_LIMIT]  = CFG_DW'($urandom_range(1, 8));
		v[REG_IDLE_LIMIT]   = CFG_DW'($urandom_range(1, 16));
		case (ph)
			1: begin
				v[REG_PRESS_DELTA] = '0;
				v[REG_STUCK_LIMIT] = CFG_DW'(1);
				v[REG_IDLE_LIMIT]  = CFG_DW'(1);
			end
			2: begin
				v[REG_PEAK_TO_PEAK] = CFG_DW'(1023);
				v[REG_PRESS_DELTA]  = CFG_DW'(511);
				v[REG_STUCK_LIMIT]  = CFG_DW'(255);
				v[REG_IDLE_LIMIT]   = CFG_DW'(255);
			end
			3: begin
				// zero thresholds wrap to 256 counts
				v[REG_PEAK_TO_PEAK] = '0;
				v[REG_STUCK_LIMIT]  = '0;
				v[REG_IDLE_LIMIT]   = '0;
			end
			4: begin
				// bits above the register widths must be dropped
				v[REG_PRESS_DELTA] = v[REG_PRESS_DELTA] | 10'h200;
				v[REG_STUCK_LIMIT] = v[REG_STUCK_LIMIT] | 10'h300;
				v[REG_IDLE_LIMIT]  = v[REG_IDLE_LIMIT] | 10'h300;
			end
			5: begin
				v[REG_PRESS_DELTA] = CFG_DW'($urandom_range(0, 511));
			end
			default: ;
		endcase
	endtask

	initial begin
		logic [CFG_DW-1:0] regs [4];
		logic [CFG_DW-1:0] one [4];
		logic [SB-1:0]     level;
		logic [7:0]        blk_thr, idl_thr;
		int                made, run;
		bit                long_ok;

		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_idx          <= REG_PEAK_TO_PEAK;
		cfg_wdata        <= '0;
		sample_ch.valid  <= 1'b0;
		sample_ch.sample <= '0;
		beat_typed       <= 1'b0;
		beat_want        <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].wr) begin
				one = '{default: '0};
				one[script[i].idx] = script[i].wdata;
				write_regs(one, 4'b0001 << script[i].idx);
			end else begin
				repeat (script[i].reps) push_sample(script[i].sample, script[i].typed, script[i].want);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			pick_setting(ph, regs);
			write_regs(regs, 4'hF);
			blk_thr = regs[REG_STUCK_LIMIT][7:0];
			idl_thr = regs[REG_IDLE_LIMIT][7:0];
			long_ok = (blk_thr == 0 || blk_thr > 64 || idl_thr == 0 || idl_thr > 64);
			made = 0;
			while (made < 40) begin
				if ($urandom_range(0, 9) < 7) begin
					// held level: the average settles and pressure stops moving
					case ($urandom_range(0, 3))
						0:       level = '0;
						1:       level = SB'(SAMPLE_MAX);
						default: level = SB'($urandom_range(0, SAMPLE_MAX));
					endcase
					run = (long_ok && $urandom_range(0, 7) == 0) ? $urandom_range(260, 320)
						: $urandom_range(4, 30);
					repeat (run) push_sample(level, 1'b0, '0);
				end else begin
					run = $urandom_range(1, 8);
					repeat (run) push_sample(SB'($urandom_range(0, SAMPLE_MAX)), 1'b0, '0);
				end
				made += run;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_pressure_sensor_autorange: done, clean");
		end else begin
			$display("tb_pressure_sensor_autorange: done, errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout, %0d results outstanding", $time, pending_readings.size());
		$display("tb_pressure_sensor_autorange: done, errors");
		$finish;
	end

endmodule
